/* src/rau_pkg.sv */
// Shared types and constants for the rational arithmetic unit.
`timescale 1ns / 1ps

package rau_pkg;

    localparam int OPERAND_BITS_DEF = 16;

    // operation codes
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROD,
        ST_FORM,
        ST_GCD,
        ST_QNUM,
        ST_QDEN,
        ST_DONE
    } rau_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic prod;
        logic form;
        logic gcd_step;
        logic div_start;
        logic div_step;
        logic div_sel_den;
        logic take_num;
        logic take_den;
    } rau_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic bad;
        logic gcd_done;
        logic div_done;
    } rau_stat_t;

endpackage

/* src/rau_datapath.sv */
// Datapath: products, sign handling, Euclidean GCD and exact division.
`timescale 1ns / 1ps

module rau_datapath #(
    parameter int OPERAND_BITS = rau_pkg::OPERAND_BITS_DEF
) (
    input  logic                        aclk,
    input  rau_pkg::rau_cmd_t           cmd,
    output rau_pkg::rau_stat_t          stat,
    input  logic [1:0]                  op_in,
    input  logic [OPERAND_BITS-1:0]     a_num_in,
    input  logic [OPERAND_BITS-1:0]     a_den_in,
    input  logic [OPERAND_BITS-1:0]     b_num_in,
    input  logic [OPERAND_BITS-1:0]     b_den_in,
    output logic [2*OPERAND_BITS:0]     result_num,
    output logic [2*OPERAND_BITS-2:0]   result_den,
    output logic                        error
);
    import rau_pkg::*;

    localparam int N  = OPERAND_BITS;
    localparam int W  = 2 * N;            // magnitude width of products
    localparam int CW = $clog2(W + 1);

    logic [1:0]   op_reg;
    logic [N-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic         ans_reg, ads_reg, bns_reg, bds_reg;
    logic [W-1:0] p1_reg, p2_reg, pd_reg;
    logic [W-1:0] num_reg, den_reg;
    logic         nums_reg;
    logic [W-1:0] ga_reg, gb_reg;
    logic [W-1:0] rem_reg, quo_reg, dvd_reg;
    logic [CW-1:0] cnt_reg;
    logic [W:0]   out_num_reg;
    logic [W-2:0] out_den_reg;
    logic         err_reg;

    logic         an_s, ad_s, bn_s, bd_s;
    logic [N-1:0] an_m, ad_m, bn_m, bd_m;
    logic         in_bad;

    // sign and magnitude of the inputs
    always_comb begin
        an_s = a_num_in[N-1];
        ad_s = a_den_in[N-1];
        bn_s = b_num_in[N-1];
        bd_s = b_den_in[N-1];
        an_m = an_s ? (~a_num_in + 1'b1) : a_num_in;
        ad_m = ad_s ? (~a_den_in + 1'b1) : a_den_in;
        bn_m = bn_s ? (~b_num_in + 1'b1) : b_num_in;
        bd_m = bd_s ? (~b_den_in + 1'b1) : b_den_in;
        in_bad = (ad_m == '0) || (bd_m == '0) || (op_in == OP_DIV && bn_m == '0);
    end

    // operand after subtract/divide rewriting
    logic         e_bns, e_bds;
    logic [N-1:0] e_bn, e_bd;
    always_comb begin
        e_bns = bn_s;
        e_bds = bd_s;
        e_bn  = bn_m;
        e_bd  = bd_m;
        case (op_in)
            OP_SUB: e_bns = ~bn_s;
            OP_DIV: begin
                e_bns = bd_s;
                e_bds = bn_s;
                e_bn  = bd_m;
                e_bd  = bn_m;
            end
            default: ;
        endcase
    end

    // raw fraction from the products
    logic [W-1:0] f_num;
    logic         f_nums;
    logic         s1, s2;
    always_comb begin
        s1 = ans_reg ^ bds_reg;
        s2 = bns_reg ^ ads_reg;
        if (op_reg == OP_ADD || op_reg == OP_SUB) begin
            if (s1 == s2) begin
                f_num  = p1_reg + p2_reg;
                f_nums = s1;
            end else if (p1_reg >= p2_reg) begin
                f_num  = p1_reg - p2_reg;
                f_nums = s1;
            end else begin
                f_num  = p2_reg - p1_reg;
                f_nums = s2;
            end
        end else begin
            f_num  = p1_reg;
            f_nums = ans_reg ^ bns_reg;
        end
        if (ads_reg ^ bds_reg) f_nums = ~f_nums;
        if (f_num == '0) f_nums = 1'b0;
    end

    // one restoring division step shared by GCD remainder and reductions
    logic [W:0]   trial;
    logic [W-1:0] rem_shift;
    logic         q_bit;
    always_comb begin
        rem_shift = {rem_reg[W-2:0], dvd_reg[W-1]};
        trial     = {rem_reg, dvd_reg[W-1]} - {1'b0, gb_reg};
        q_bit     = ~trial[W];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg  <= op_in;
            an_reg  <= an_m;
            ad_reg  <= ad_m;
            bn_reg  <= e_bn;
            bd_reg  <= e_bd;
            ans_reg <= an_s;
            ads_reg <= ad_s;
            bns_reg <= e_bns;
            bds_reg <= e_bds;
            err_reg <= in_bad;
        end
        if (cmd.prod) begin
            p1_reg <= (op_reg == OP_ADD || op_reg == OP_SUB)
                      ? W'(an_reg * bd_reg) : W'(an_reg * bn_reg);
            p2_reg <= W'(bn_reg * ad_reg);
            pd_reg <= W'(ad_reg * bd_reg);
        end
        if (cmd.form) begin
            num_reg  <= f_num;
            nums_reg <= f_nums;
            den_reg  <= pd_reg;
            ga_reg   <= f_num;
            gb_reg   <= pd_reg;
            rem_reg  <= '0;
            dvd_reg  <= f_num;
            cnt_reg  <= CW'(W);
        end
        // GCD: a serial remainder pass per Euclid step
        if (cmd.gcd_step) begin
            if (cnt_reg != '0) begin
                rem_reg <= q_bit ? trial[W-1:0] : rem_shift;
                dvd_reg <= {dvd_reg[W-2:0], 1'b0};
                cnt_reg <= cnt_reg - 1'b1;
            end else begin
                ga_reg  <= gb_reg;
                gb_reg  <= rem_reg;
                rem_reg <= '0;
                dvd_reg <= gb_reg;
                cnt_reg <= CW'(W);
            end
        end
        if (cmd.div_start) begin
            gb_reg  <= ga_reg;
            rem_reg <= '0;
            quo_reg <= '0;
            dvd_reg <= cmd.div_sel_den ? den_reg : num_reg;
            cnt_reg <= CW'(W);
        end
        if (cmd.div_step) begin
            rem_reg <= q_bit ? trial[W-1:0] : rem_shift;
            dvd_reg <= {dvd_reg[W-2:0], 1'b0};
            quo_reg <= {quo_reg[W-2:0], q_bit};
            cnt_reg <= cnt_reg - 1'b1;
        end
        if (cmd.take_num) begin
            out_num_reg <= nums_reg ? (~{1'b0, quo_reg} + 1'b1) : {1'b0, quo_reg};
        end
        if (cmd.take_den) begin
            out_den_reg <= quo_reg[W-2:0];
        end
    end

    assign stat.bad      = err_reg;
    assign stat.gcd_done = (gb_reg == '0);
    assign stat.div_done = (cnt_reg == '0);

    assign result_num = err_reg ? '0 : out_num_reg;
    assign result_den = err_reg ? (W-1)'(1) : out_den_reg;
    assign error      = err_reg;

endmodule

/* src/rau_ctrl.sv */
// Controller state machine sequencing one transaction through the datapath.
`timescale 1ns / 1ps

module rau_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_fire,
    input  logic                out_fire,
    input  rau_pkg::rau_stat_t  stat,
    output rau_pkg::rau_cmd_t   cmd,
    output logic                busy,
    output logic                done
);
    import rau_pkg::*;

    rau_state_t state_reg, state_next;

    // advance state
    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_fire) state_next = ST_PROD;
            ST_PROD: state_next = stat.bad ? ST_DONE : ST_FORM;
            ST_FORM: state_next = ST_GCD;
            ST_GCD:  if (stat.gcd_done) state_next = ST_QNUM;
            ST_QNUM: if (stat.div_done) state_next = ST_QDEN;
            ST_QDEN: if (stat.div_done) state_next = ST_DONE;
            ST_DONE: if (out_fire) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // a flag marks the first cycle in each newly entered state, including each quotient pass
    logic first_reg, first_next;
    assign first_next = (state_next != state_reg);
    always_ff @(posedge aclk) begin
        if (!aresetn) first_reg <= 1'b0;
        else          first_reg <= first_next;
    end

    // outputs
    always_comb begin
        cmd = '0;
        busy = 1'b1;
        done = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                busy = 1'b0;
                cmd.load = in_fire;
            end
            ST_PROD: cmd.prod = 1'b1;
            ST_FORM: cmd.form = 1'b1;
            ST_GCD:  cmd.gcd_step = ~stat.gcd_done;
            ST_QNUM: begin
                if (first_reg) begin
                    cmd.div_start = 1'b1;
                end else if (stat.div_done) begin
                    cmd.take_num    = 1'b1;
                    cmd.div_start   = 1'b1;
                    cmd.div_sel_den = 1'b1;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_QDEN: begin
                if (stat.div_done && !first_reg) cmd.take_den = 1'b1;
                else if (!first_reg) cmd.div_step = 1'b1;
                else cmd.div_step = 1'b1;
            end
            ST_DONE: done = 1'b1;
            default: ;
        endcase
    end

endmodule

/* src/rational_arithmetic_unit.sv */
// Top level of the rational arithmetic unit: stream ports, controller, datapath.
//
//  channel | dir | tdata fields (low bit up)
//  s_axis  | in  | operation[1:0], a_num, a_den, b_num, b_den (OPERAND_BITS each)
//  m_axis  | out | result_num (2N+1), result_den (2N-1); tuser = error
//
// One transaction at a time. After acceptance a result passes through the
// product and fraction states, the Euclidean GCD passes and the numerator and
// denominator quotient passes of the bit-serial remainder unit before tvalid.
// Error cases go from the product state straight to tvalid. Once the result is
// taken, the controller returns to idle and the input opens again.
// Reset is synchronous, active low, and returns the controller to idle.
// A stalled result holds on m_axis until m_axis_tready.
`timescale 1ns / 1ps

module rational_arithmetic_unit #(
    parameter int OPERAND_BITS = rau_pkg::OPERAND_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // operation, a_num, a_den, b_num, b_den, zero fill
    input  logic [((4*OPERAND_BITS+2+7)/8)*8-1:0]  s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // result_num, result_den
    output logic [4*OPERAND_BITS-1:0]              m_axis_tdata,
    // error
    output logic                                   m_axis_tuser
);
    import rau_pkg::*;

    localparam int N = OPERAND_BITS;

    rau_cmd_t  cmd;
    rau_stat_t stat;
    logic      busy, done;
    logic      in_fire, out_fire;
    logic [2*N:0]   res_num;
    logic [2*N-2:0] res_den;

    assign s_axis_tready = ~busy & aresetn;
    assign m_axis_tvalid = done;
    assign in_fire  = s_axis_tvalid & s_axis_tready;
    assign out_fire = m_axis_tvalid & m_axis_tready;

    rau_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .out_fire (out_fire),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy),
        .done     (done)
    );

    rau_datapath #(.OPERAND_BITS(N)) u_dp (
        .aclk       (aclk),
        .cmd        (cmd),
        .stat       (stat),
        .op_in      (s_axis_tdata[1:0]),
        .a_num_in   (s_axis_tdata[2+N-1:2]),
        .a_den_in   (s_axis_tdata[2+2*N-1:2+N]),
        .b_num_in   (s_axis_tdata[2+3*N-1:2+2*N]),
        .b_den_in   (s_axis_tdata[2+4*N-1:2+3*N]),
        .result_num (res_num),
        .result_den (res_den),
        .error      (m_axis_tuser)
    );

    assign m_axis_tdata = {res_den, res_num};

    // result channel and input channel never both open
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_axis_tready && m_axis_tvalid))
        else $error("ready and valid together");

    // a result denominator is never zero
    a_den: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (res_den != '0))
        else $error("zero denominator out");

    // an accepted transaction closes the input side next cycle
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> !s_axis_tready)
        else $error("input stayed open");

endmodule

/* test/testbench.sv */
// Self-checking testbench for the rational arithmetic unit stream block.
`timescale 1ns / 1ps

module testbench;
    import rau_pkg::*;

    localparam int N = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [2*N:0]   num;
        logic [2*N-2:0] den;
        logic           err;
    } fraction_t;

    logic            aclk;
    logic            aresetn;
    logic            s_axis_tvalid;
    logic            s_axis_tready;
    logic [71:0]     s_axis_tdata;
    logic            m_axis_tvalid;
    logic            m_axis_tready;
    logic [4*N-1:0]  m_axis_tdata;
    logic            m_axis_tuser;

    fraction_t expected_fractions[$];
    int        mismatches;
    int        hold_left;
    bit        idle_on;

    rational_arithmetic_unit #(.OPERAND_BITS(N)) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // exact fraction arithmetic, reduced by Euclid, sign on the numerator
    function automatic fraction_t reduce_fraction(input logic [1:0] op,
            input logic signed [N-1:0] an, input logic signed [N-1:0] ad,
            input logic signed [N-1:0] bn, input logic signed [N-1:0] bd);
        fraction_t f;
        longint num, den, x, y, r, sbn, sbd;
        f.err = 1'b0;
        if (ad == 0 || bd == 0 || (op == OP_DIV && bn == 0)) begin
            f.num = '0;
            f.den = (2*N-1)'(1);
            f.err = 1'b1;
            return f;
        end
        sbn = bn;
        sbd = bd;
        if (op == OP_SUB) begin
            sbn = -sbn;
        end else if (op == OP_DIV) begin
            sbn = bd;
            sbd = bn;
        end
        if (op == OP_ADD || op == OP_SUB)
            num = longint'(an) * sbd + sbn * longint'(ad);
        else
            num = longint'(an) * sbn;
        den = longint'(ad) * sbd;
        if (den < 0) begin
            num = -num;
            den = -den;
        end
        x = (num < 0) ? -num : num;
        y = den;
        while (y > 0) begin
            r = x % y;
            x = y;
            y = r;
        end
        f.num = (2*N+1)'(num / x);
        f.den = (2*N-1)'(den / x);
        return f;
    endfunction

    // pick an idle gap: mostly none or short, sometimes long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (!idle_on || r < 55) return 0;
        if (r < 90) return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    // offer one transaction and log its expected result once accepted
    task automatic send_item(input logic [1:0] op, input logic [N-1:0] an,
            input logic [N-1:0] ad, input logic [N-1:0] bn, input logic [N-1:0] bd);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, bd, bn, ad, an, op};
        do @(posedge aclk); while (!(s_axis_tvalid && s_axis_tready));
        expected_fractions.push_back(reduce_fraction(op, an, ad, bn, bd));
    endtask

    function automatic logic [N-1:0] pick_operand(input bit is_den);
        int r;
        r = $urandom_range(99);
        if (is_den && r < 3) return '0;
        if (r < 45) return N'($urandom);
        if (r < 55) begin
            case ($urandom_range(3))
                0: return 16'h8000;
                1: return 16'h7fff;
                2: return 16'hffff;
                default: return 16'h0001;
            endcase
        end
        return N'($signed($urandom_range(40)) - 20);
    endfunction

    // check each returned transaction against the oldest expectation
    initial begin
        fraction_t want;
        int stall;
        stall = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_fractions.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result num=%0d den=%0d err=%b",
                                 $signed(m_axis_tdata[2*N:0]),
                                 m_axis_tdata[4*N-1:2*N+1], m_axis_tuser);
                end else begin
                    want = expected_fractions.pop_front();
                    if (m_axis_tdata[2*N:0] !== want.num ||
                        m_axis_tdata[4*N-1:2*N+1] !== want.den ||
                        m_axis_tuser !== want.err) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %0d/%0d err=%b, got %0d/%0d err=%b",
                                     $signed(want.num), want.den, want.err,
                                     $signed(m_axis_tdata[2*N:0]),
                                     m_axis_tdata[4*N-1:2*N+1], m_axis_tuser);
                    end
                end
            end
            // drive ready: long hold-off first, then random stalls
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                m_axis_tready <= 1'b0;
            end else begin
                stall = pick_gap();
                m_axis_tready <= (stall == 0);
            end
        end
    end

    // watchdog: cycles with no transaction on either side
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge aclk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("testbench: errors");
                $finish;
            end
        end
    end

    task automatic test_extremes();
        logic [N-1:0] v[5];
        v = '{16'h8000, 16'h7fff, 16'h0001, 16'hffff, 16'h0003};
        for (int op = 0; op < 4; op++) begin
            send_item(op[1:0], v[op], v[(op + 1) % 5], v[(op + 2) % 5], v[(op + 3) % 5]);
            send_item(op[1:0], 16'h8000, 16'h8000, 16'h8000, 16'h7fff);
        end
        // largest numerator and a zero result
        send_item(OP_MUL, 16'h8000, 16'h0001, 16'h8000, 16'h0001);
        send_item(OP_ADD, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
        send_item(OP_SUB, 16'h0005, 16'h0007, 16'h0005, 16'h0007);
        send_item(OP_MUL, 16'h0000, 16'hfff9, 16'h1234, 16'h0003);
        // negative denominators
        send_item(OP_DIV, 16'h0006, 16'hfffc, 16'hfff7, 16'h0002);
    endtask

    task automatic test_error_cases();
        for (int op = 0; op < 4; op++) begin
            send_item(op[1:0], 16'h0003, 16'h0000, 16'h0002, 16'h0005);
            send_item(op[1:0], 16'h0003, 16'h0004, 16'h0002, 16'h0000);
        end
        send_item(OP_DIV, 16'h0003, 16'h0004, 16'h0000, 16'h0005);
        send_item(OP_MUL, 16'h0003, 16'h0004, 16'h0000, 16'h0005);
    endtask

    task automatic test_backpressure();
        hold_left = 3000;
        for (int i = 0; i < 6; i++)
            send_item(2'($urandom), pick_operand(0), pick_operand(1),
                      pick_operand(0), pick_operand(1));
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++) begin
            if (i % 200 == 0) idle_on = $urandom_range(3) != 0;
            send_item(2'($urandom), pick_operand(0), pick_operand(1),
                      pick_operand(0), pick_operand(1));
        end
    endtask

    initial begin
        mismatches    = 0;
        hold_left     = 0;
        idle_on       = 1'b1;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_extremes();
        test_error_cases();
        test_backpressure();
        test_random(1270);
        s_axis_tvalid <= 1'b0;
        // drain outstanding results, then let the block settle
        while (expected_fractions.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (mismatches == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
